### rtl/mjq_pkg.sv
// Shared types, constants and fixed-point helpers for the minimum-jerk
// quintic coefficient block. No dependencies.
package mjq_pkg;

  // Default number of fraction bits of every fixed-point field.
  localparam int FRACTION_BITS_DEF = 16;

  // Field widths.
  localparam int DATA_W = 32;
  localparam int DUR_W  = 24;

  // Wide intermediates: signed, clamped to +-(2^58 - 1).
  localparam int WIDE_W = 59;
  localparam int MAG_W  = 58;

  // Divider: bits resolved per pipeline stage, stage count and latency.
  localparam int DIV_BPS  = 2;
  localparam int DIV_ITER = MAG_W / DIV_BPS;
  localparam int DIV_LAT  = DIV_ITER + 3;

  // Depth of the queues between the parts of the block.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [MAG_W-1:0]   MAG_MAX = '1;
  localparam logic signed [63:0] LIM64   = 64'sh03FF_FFFF_FFFF_FFFF;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    data_t              start_position;
    data_t              start_velocity;
    data_t              start_acceleration;
    data_t              end_position;
    data_t              end_velocity;
    data_t              end_acceleration;
    logic [DUR_W-1:0]   duration;
  } in_item_t;

  typedef struct packed {
    data_t      coef_zero;
    data_t      coef_one;
    data_t      coef_two;
    data_t      coef_three;
    data_t      coef_four;
    data_t      coef_five;
    logic [1:0] status;
  } out_item_t;

  // Coefficients that need no division, plus the zero-duration flag.
  typedef struct packed {
    data_t c0;
    data_t c1;
    data_t c2;
    logic  zero;
  } base_t;

  // Classified segment handed from the front to the back.
  typedef struct packed {
    base_t            base;
    logic [DUR_W-1:0] dur;
    wide_t            h10;
    wide_t            h15n;
    wide_t            h6;
    wide_t            dv4n;
    wide_t            dv7;
    wide_t            dv3n;
    wide_t            hda;
    wide_t            dan;
  } mid_item_t;

  // Side data carried along each division level.
  typedef struct packed {
    base_t base;
    wide_t dv4n;
    wide_t dv7;
    wide_t dv3n;
    wide_t hda;
    wide_t dan;
  } side1_t;

  typedef struct packed {
    base_t base;
    wide_t hda;
    wide_t dan;
  } side2_t;

  typedef struct packed {
    base_t base;
    wide_t x3;
  } side4_t;

  typedef struct packed {
    base_t base;
    wide_t x3;
    wide_t x4;
  } side5_t;

  // Clamp a 64-bit signed value to the wide range.
  function automatic wide_t sat64(logic signed [63:0] x);
    if (x > LIM64) return WIDE_W'(LIM64);
    if (x < -LIM64) return WIDE_W'(-LIM64);
    return WIDE_W'(x);
  endfunction

  // Magnitude of a clamped wide value.
  function automatic logic [MAG_W-1:0] mag_w(wide_t x);
    wide_t n;
    n = -x;
    return x[WIDE_W-1] ? MAG_W'(n) : MAG_W'(x);
  endfunction

  // Rebuild a signed wide value from magnitude and sign.
  function automatic wide_t apply_sign(logic [MAG_W-1:0] m, logic neg);
    wide_t w;
    w = wide_t'({1'b0, m});
    return neg ? -w : w;
  endfunction

  // Halve, rounding ties away from zero.
  function automatic wide_t half_w(wide_t x);
    logic [MAG_W:0] t;
    t = ({1'b0, mag_w(x)} + 1'b1) >> 1;
    return apply_sign(MAG_W'(t), x[WIDE_W-1]);
  endfunction

endpackage

### rtl/mjq_fifo.sv
// Small register-based queue used between the front, the back and the
// result port. Depends on nothing but its parameters.
module mjq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push_ok, pop_ok;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/mjq_div.sv
// Pipelined fixed-point divider x * 2^F / d over several lanes that share d.
// Adds two operands, clamps, then resolves two quotient bits per stage.
// Depends on mjq_pkg.
module mjq_div #(
  parameter int FRACTION_BITS = mjq_pkg::FRACTION_BITS_DEF,
  parameter int LANES         = 1,
  parameter int SIDE_W        = 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_vld,
  input  mjq_pkg::wide_t [LANES-1:0]        in_a,
  input  mjq_pkg::wide_t [LANES-1:0]        in_b,
  input  logic [mjq_pkg::DUR_W-1:0]         in_d,
  input  logic [SIDE_W-1:0]                 in_side,
  output logic                              out_vld,
  output mjq_pkg::wide_t [LANES-1:0]        out_q,
  output logic [mjq_pkg::DUR_W-1:0]         out_d,
  output logic [SIDE_W-1:0]                 out_side
);
  import mjq_pkg::*;

  // Bits of the magnitude that lie below the binary point after scaling.
  localparam int LOW_W = MAG_W - FRACTION_BITS;

  typedef struct packed {
    logic [DUR_W-1:0] rem;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] quo;
  } div_st_t;

  logic [DIV_LAT-1:0] vld_r;
  logic [DUR_W-1:0]   d_r    [DIV_LAT];
  logic [SIDE_W-1:0]  side_r [DIV_LAT];

  logic               neg0_r [LANES];
  logic [MAG_W-1:0]   m0_r   [LANES];
  div_st_t            st_r   [DIV_ITER+1][LANES];
  logic               neg_r  [DIV_ITER+1][LANES];
  logic               ovf_r  [DIV_ITER+1][LANES];
  wide_t              qf_r   [LANES];

  // One stage of restoring division.
  function automatic div_st_t div_step(div_st_t s, logic [DUR_W-1:0] d);
    div_st_t        r;
    logic [DUR_W:0] trial;
    r = s;
    for (int b = 0; b < DIV_BPS; b++) begin
      trial = {r.rem, r.num[MAG_W-1]};
      r.num = {r.num[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        r.rem = DUR_W'(trial - {1'b0, d});
        r.quo = {r.quo[MAG_W-2:0], 1'b1};
      end else begin
        r.rem = trial[DUR_W-1:0];
        r.quo = {r.quo[MAG_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_LAT-2:0], in_vld};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    logic signed [63:0] sum;
    wide_t              s;
    logic [DUR_W-1:0]   head;
    logic               rnd;
    logic [MAG_W-1:0]   q;
    div_st_t            fin;
    if (en) begin
      d_r[0]    <= in_d;
      side_r[0] <= in_side;
      for (int k = 1; k < DIV_LAT; k++) begin
        d_r[k]    <= d_r[k-1];
        side_r[k] <= side_r[k-1];
      end
      for (int l = 0; l < LANES; l++) begin
        // Operand sum, clamp and sign split.
        sum       = 64'(in_a[l]) + 64'(in_b[l]);
        s         = sat64(sum);
        neg0_r[l] <= s[WIDE_W-1];
        m0_r[l]   <= mag_w(s);
        // The integer part of the scaled numerator must stay below d.
        head               = DUR_W'(m0_r[l] >> LOW_W);
        ovf_r[0][l]        <= (head >= d_r[0]);
        neg_r[0][l]        <= neg0_r[l];
        st_r[0][l].rem     <= head;
        st_r[0][l].num     <= MAG_W'(m0_r[l] << FRACTION_BITS);
        st_r[0][l].quo     <= '0;
        for (int k = 1; k <= DIV_ITER; k++) begin
          st_r[k][l]  <= div_step(st_r[k-1][l], d_r[k]);
          neg_r[k][l] <= neg_r[k-1][l];
          ovf_r[k][l] <= ovf_r[k-1][l];
        end
        // Round to nearest and clamp to the wide range.
        fin = st_r[DIV_ITER][l];
        rnd = ({fin.rem, 1'b0} >= {1'b0, d_r[DIV_ITER+1]});
        if (ovf_r[DIV_ITER][l] || (fin.quo == MAG_MAX && rnd)) begin
          q = MAG_MAX;
        end else begin
          q = fin.quo + MAG_W'(rnd);
        end
        qf_r[l] <= apply_sign(q, neg_r[DIV_ITER][l]);
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_q[l] = qf_r[l];
    end
  end

  assign out_vld  = vld_r[DIV_LAT-1];
  assign out_d    = d_r[DIV_LAT-1];
  assign out_side = side_r[DIV_LAT-1];

endmodule

### rtl/mjq_front.sv
// Front part: takes a segment, forms the end-state residuals and their
// constant multiples, and flags zero duration. Depends on mjq_pkg.
module mjq_front #(
  parameter int FRACTION_BITS = mjq_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  mjq_pkg::in_item_t   in_item,
  output logic                out_vld,
  output mjq_pkg::mid_item_t  out_item
);
  import mjq_pkg::*;

  localparam int PROD_W    = DATA_W + DUR_W;
  localparam int TA_MAG_W  = PROD_W - FRACTION_BITS;
  localparam int TA_LO_W   = DUR_W;
  localparam int TA_HI_W   = TA_MAG_W - TA_LO_W;
  localparam int TP_W      = TA_MAG_W + DUR_W + 1;
  localparam int CMP_W     = TP_W + MAG_W;
  localparam logic [PROD_W-1:0] ROUND_P = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic [TP_W-1:0]   ROUND_T = TP_W'(1) << (FRACTION_BITS - 1);

  logic [6:0] vld_r;

  // Stage 0 and 1.
  in_item_t            it0_r, it1_r, it2_r;
  logic [PROD_W-1:0]   pv1_r, pa1_r;
  logic                nv1_r, na1_r;
  data_t               c2_1_r, c2_2_r;
  // Stage 2.
  wide_t               tv2_r, ta2_r;
  logic [TA_MAG_W-1:0] tam2_r;
  logic                tan2_r;
  // Stage 3.
  base_t               base3_r, base4_r, base5_r, base6_r;
  logic [DUR_W-1:0]    d3_r, d4_r, d5_r, d6_r;
  logic [2*DUR_W-1:0]  p3_r;
  logic [TA_HI_W+DUR_W-1:0] q3_r;
  logic                tan3_r;
  wide_t               h3_r, dv3_r, da3_r;
  // Stage 4.
  wide_t               taa4_r, h4_r, dv4_r, da4_r;
  // Stage 5.
  wide_t               h5_r, dv5_r, da5_r, hda5_r;
  // Stage 6.
  wide_t               h10_r, h15n_r, h6_r, dv4n_r, dv7_r, dv3n_r, hda6_r, dan_r;

  function automatic logic [DATA_W-1:0] mag32(data_t x);
    data_t n;
    n = -x;
    return x[DATA_W-1] ? DATA_W'(n) : DATA_W'(x);
  endfunction

  // Valid bits of the seven stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [PROD_W-1:0]   tr;
    logic [TA_MAG_W-1:0] tvm, tam;
    wide_t               h1, dvx;
    logic [TP_W-1:0]     tp;
    logic [MAG_W-1:0]    taam;
    if (en) begin
      // Capture the beat.
      it0_r <= in_item;

      // Velocity and acceleration times the duration.
      it1_r  <= it0_r;
      pv1_r  <= PROD_W'(mag32(it0_r.start_velocity)) * PROD_W'(it0_r.duration);
      pa1_r  <= PROD_W'(mag32(it0_r.start_acceleration)) * PROD_W'(it0_r.duration);
      nv1_r  <= it0_r.start_velocity[DATA_W-1];
      na1_r  <= it0_r.start_acceleration[DATA_W-1];
      c2_1_r <= DATA_W'(half_w(WIDE_W'(it0_r.start_acceleration)));

      // Round and rescale to get v0 T and a0 T.
      it2_r  <= it1_r;
      c2_2_r <= c2_1_r;
      tr     = (pv1_r + ROUND_P) >> FRACTION_BITS;
      tvm    = TA_MAG_W'(tr);
      tr     = (pa1_r + ROUND_P) >> FRACTION_BITS;
      tam    = TA_MAG_W'(tr);
      tv2_r  <= apply_sign(MAG_W'(tvm), nv1_r);
      ta2_r  <= apply_sign(MAG_W'(tam), na1_r);
      tam2_r <= tam;
      tan2_r <= na1_r;

      // Split a0 T times T into two partial products; form residuals.
      base3_r.c0   <= it2_r.start_position;
      base3_r.c1   <= it2_r.start_velocity;
      base3_r.c2   <= c2_2_r;
      base3_r.zero <= (it2_r.duration == '0);
      d3_r   <= it2_r.duration;
      p3_r   <= (2*DUR_W)'(tam2_r[TA_LO_W-1:0]) * (2*DUR_W)'(it2_r.duration);
      q3_r   <= (TA_HI_W+DUR_W)'(tam2_r[TA_MAG_W-1:TA_LO_W])
                * (TA_HI_W+DUR_W)'(it2_r.duration);
      tan3_r <= tan2_r;
      h1     = sat64(64'(it2_r.end_position) - 64'(it2_r.start_position));
      h3_r   <= sat64(64'(h1) - 64'(tv2_r));
      dvx    = sat64(64'(it2_r.end_velocity) - 64'(it2_r.start_velocity));
      dv3_r  <= sat64(64'(dvx) - 64'(ta2_r));
      da3_r  <= sat64(64'(it2_r.end_acceleration) - 64'(it2_r.start_acceleration));

      // Combine, round and clamp a0 T^2.
      base4_r <= base3_r;
      d4_r    <= d3_r;
      tp      = TP_W'(p3_r) + (TP_W'(q3_r) << TA_LO_W) + ROUND_T;
      tp      = tp >> FRACTION_BITS;
      if (CMP_W'(tp) > CMP_W'(MAG_MAX)) begin
        taam = MAG_MAX;
      end else begin
        taam = MAG_W'(tp);
      end
      taa4_r <= apply_sign(taam, tan3_r);
      h4_r   <= h3_r;
      dv4_r  <= dv3_r;
      da4_r  <= da3_r;

      // Finish the position residual.
      base5_r <= base4_r;
      d5_r    <= d4_r;
      h5_r    <= sat64(64'(h4_r) - 64'(half_w(taa4_r)));
      dv5_r   <= dv4_r;
      da5_r   <= da4_r;
      hda5_r  <= half_w(da4_r);

      // Constant multiples that feed the divisions.
      base6_r <= base5_r;
      d6_r    <= d5_r;
      h10_r   <= sat64(64'(h5_r) * 64'sd10);
      h15n_r  <= sat64(-(64'(h5_r) * 64'sd15));
      h6_r    <= sat64(64'(h5_r) * 64'sd6);
      dv4n_r  <= -sat64(64'(dv5_r) * 64'sd4);
      dv7_r   <= sat64(64'(dv5_r) * 64'sd7);
      dv3n_r  <= -sat64(64'(dv5_r) * 64'sd3);
      hda6_r  <= hda5_r;
      dan_r   <= -da5_r;
    end
  end

  always_comb begin
    out_item.base = base6_r;
    out_item.dur  = d6_r;
    out_item.h10  = h10_r;
    out_item.h15n = h15n_r;
    out_item.h6   = h6_r;
    out_item.dv4n = dv4n_r;
    out_item.dv7  = dv7_r;
    out_item.dv3n = dv3n_r;
    out_item.hda  = hda6_r;
    out_item.dan  = dan_r;
  end

  assign out_vld = vld_r[6];

endmodule

### rtl/mjq_back.sv
// Back part: five levels of pipelined division that build the cubic,
// quartic and quintic coefficients, then the final clamp and status.
// Depends on mjq_pkg and mjq_div.
module mjq_back #(
  parameter int FRACTION_BITS = mjq_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  mjq_pkg::mid_item_t  in_item,
  output logic                out_vld,
  output mjq_pkg::out_item_t  out_item
);
  import mjq_pkg::*;

  typedef struct packed {
    data_t v;
    logic  clamped;
  } fit_t;

  logic             vld1, vld2, vld3, vld4, vld5;
  logic [DUR_W-1:0] d1, d2, d3, d4, d5;
  wide_t [2:0]      a1, q1, b2, q2, b3, q3;
  wide_t [1:0]      a4, q4;
  wide_t [0:0]      a5, q5;
  side1_t           s1_in, s1_out;
  side2_t           s2_in, s2_out;
  base_t            s3_out;
  side4_t           s4_in, s4_out;
  side5_t           s5_in, s5_out;
  fit_t             f3, f4, f5;

  function automatic fit_t fit32(wide_t x);
    fit_t r;
    if (x > WIDE_W'(64'sh7FFF_FFFF)) begin
      r.v       = 32'sh7FFF_FFFF;
      r.clamped = 1'b1;
    end else if (x < -WIDE_W'(64'sh8000_0000)) begin
      r.v       = 32'sh8000_0000;
      r.clamped = 1'b1;
    end else begin
      r.v       = DATA_W'(x);
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  // Level one: first division of every chain. Lane 0 is the cubic,
  // lane 1 the quartic and lane 2 the quintic coefficient.
  assign a1 = {in_item.h6, in_item.h15n, in_item.h10};
  always_comb begin
    s1_in.base = in_item.base;
    s1_in.dv4n = in_item.dv4n;
    s1_in.dv7  = in_item.dv7;
    s1_in.dv3n = in_item.dv3n;
    s1_in.hda  = in_item.hda;
    s1_in.dan  = in_item.dan;
  end

  mjq_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(3), .SIDE_W($bits(side1_t))) u_div1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_vld),
    .in_a(a1), .in_b('0), .in_d(in_item.dur), .in_side(s1_in),
    .out_vld(vld1), .out_q(q1), .out_d(d1), .out_side(s1_out)
  );

  // Level two: add the velocity residual terms.
  assign b2 = {s1_out.dv3n, s1_out.dv7, s1_out.dv4n};
  always_comb begin
    s2_in.base = s1_out.base;
    s2_in.hda  = s1_out.hda;
    s2_in.dan  = s1_out.dan;
  end

  mjq_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(3), .SIDE_W($bits(side2_t))) u_div2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld1),
    .in_a(q1), .in_b(b2), .in_d(d1), .in_side(s2_in),
    .out_vld(vld2), .out_q(q2), .out_d(d2), .out_side(s2_out)
  );

  // Level three: add the acceleration residual terms.
  assign b3 = {s2_out.hda, s2_out.dan, s2_out.hda};

  mjq_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(3), .SIDE_W($bits(base_t))) u_div3 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld2),
    .in_a(q2), .in_b(b3), .in_d(d2), .in_side(s2_out.base),
    .out_vld(vld3), .out_q(q3), .out_d(d3), .out_side(s3_out)
  );

  // Level four: the cubic is done; quartic and quintic divide again.
  assign a4 = {q3[2], q3[1]};
  always_comb begin
    s4_in.base = s3_out;
    s4_in.x3   = q3[0];
  end

  mjq_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(2), .SIDE_W($bits(side4_t))) u_div4 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld3),
    .in_a(a4), .in_b('0), .in_d(d3), .in_side(s4_in),
    .out_vld(vld4), .out_q(q4), .out_d(d4), .out_side(s4_out)
  );

  // Level five: last division of the quintic.
  assign a5 = q4[1];
  always_comb begin
    s5_in.base = s4_out.base;
    s5_in.x3   = s4_out.x3;
    s5_in.x4   = q4[0];
  end

  mjq_div #(.FRACTION_BITS(FRACTION_BITS), .LANES(1), .SIDE_W($bits(side5_t))) u_div5 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld4),
    .in_a(a5), .in_b('0), .in_d(d4), .in_side(s5_in),
    .out_vld(vld5), .out_q(q5), .out_d(d5), .out_side(s5_out)
  );

  // Clamp to 32 bits, set the status and apply the zero-duration case.
  always_comb begin
    f3 = fit32(s5_out.x3);
    f4 = fit32(s5_out.x4);
    f5 = fit32(q5[0]);
    if (s5_out.base.zero || d5 == '0) begin
      out_item        = '0;
      out_item.status = ST_ZERO;
    end else begin
      out_item.coef_zero  = s5_out.base.c0;
      out_item.coef_one   = s5_out.base.c1;
      out_item.coef_two   = s5_out.base.c2;
      out_item.coef_three = f3.v;
      out_item.coef_four  = f4.v;
      out_item.coef_five  = f5.v;
      out_item.status     = (f3.clamped || f4.clamped || f5.clamped) ? ST_SAT : ST_OK;
    end
  end

  assign out_vld = vld5;

endmodule

### rtl/min_jerk_quintic_coefficients.sv
// Top level of the minimum-jerk quintic coefficient block: front, back and
// the queues between them. Depends on mjq_pkg, mjq_fifo, mjq_front, mjq_back.
//
// Usage:
//   Input side is a queue: drive in_data and raise push; a beat is taken at
//   a rising edge with push high and full low. Each beat holds a start and
//   an end state plus a duration. Result side is a queue too: while empty
//   is low the oldest result is on out_data, and it leaves at a rising edge
//   with pop high.
//   Throughput is one beat per cycle while full is low. The path from push
//   to the earliest pop runs through seven front stages, two queue hops and
//   five chained divider levels, each resolving two quotient bits per stage.
//   A zero duration gives zero coefficients with the zero-duration status.
//   Synchronous reset empties both queues and clears the valid bits of all
//   stages; no clearing pass is needed.
//   When the receiver stops popping, the result queue fills, the back
//   pipeline halts, then the middle queue fills and full rises. Nothing is
//   dropped; the flow resumes at full rate once pop returns.
module min_jerk_quintic_coefficients #(
  parameter int FRACTION_BITS = mjq_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mjq_pkg::in_item_t   in_data,
  output logic                empty,
  input  logic                pop,
  output mjq_pkg::out_item_t  out_data
);
  import mjq_pkg::*;

  logic      front_en, front_vld;
  mid_item_t front_item, mid_head;
  logic      mid_full, mid_empty, mid_pop;
  logic      back_en, back_vld, out_full;
  out_item_t back_item;

  // Front runs while the middle queue has room.
  assign front_en = !mid_full;
  assign full     = mid_full;

  mjq_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .en(front_en), .in_vld(push),
    .in_item(in_data), .out_vld(front_vld), .out_item(front_item)
  );

  mjq_fifo #(.WIDTH($bits(mid_item_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk(clk), .rst_n(rst_n), .push(front_en && front_vld), .wdata(front_item),
    .pop(mid_pop), .rdata(mid_head), .full(mid_full), .empty(mid_empty)
  );

  // Back runs while the result queue has room.
  assign back_en = !out_full;
  assign mid_pop = back_en && !mid_empty;

  mjq_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .en(back_en), .in_vld(!mid_empty),
    .in_item(mid_head), .out_vld(back_vld), .out_item(back_item)
  );

  mjq_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n), .push(back_en && back_vld), .wdata(back_item),
    .pop(pop), .rdata(out_data), .full(out_full), .empty(empty)
  );

  // Reset leaves both channels idle.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // Every result carries a defined status code.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.status == ST_OK || out_data.status == ST_SAT ||
                out_data.status == ST_ZERO))
    else $error("undefined status code on the result port");

  // A zero-duration result has its coefficients cleared; zero, two, three and five are checked.
  a_zero_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == ST_ZERO) |->
      (out_data.coef_zero == '0 && out_data.coef_two == '0 &&
       out_data.coef_three == '0 && out_data.coef_five == '0))
    else $error("zero-duration result has nonzero coefficients");

endmodule
